// ===== design/bcse_pkg.sv =====
// ----------------------------------------------------------------------------
// bcse_pkg
// Types, constants and shared arithmetic for the bivariate cubic shift
// evaluator: payload structs, fixed-point formats and the rounded Q0.16 product.
// ----------------------------------------------------------------------------
package bcse_pkg;

  // Fixed-point formats of the payload fields.
  localparam int COEF_W   = 32;           // signed Q8.24
  localparam int POS_FRAC = 16;           // Q0.16 fraction bits
  localparam int POS_W    = POS_FRAC + 1; // one extra bit so that 1.0 fits
  localparam int IDX_W    = 6;

  // Coefficient store organization.
  localparam int TERMS         = 11;
  localparam int TERM_IDX_W    = $clog2(TERMS);
  localparam int READ_ROWS     = 4;       // rows reachable through plane_sel
  localparam int ROW_W         = $clog2(READ_ROWS);
  localparam int DEF_COEF_ROWS = 4;

  // Coefficient rows.
  localparam int ROW_XR = 0;
  localparam int ROW_YR = 1;
  localparam int ROW_XB = 2;
  localparam int ROW_YB = 3;

  // Result axes.
  localparam int AXES   = 2;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

  // Monomial order inside a row.
  localparam int T_ONE  = 0;
  localparam int T_X    = 1;
  localparam int T_Y    = 2;
  localparam int T_X2   = 3;
  localparam int T_Y2   = 4;
  localparam int T_X3   = 5;
  localparam int T_Y3   = 6;
  localparam int T_XY   = 7;
  localparam int T_X2Y  = 8;
  localparam int T_XY2  = 9;
  localparam int T_X2Y2 = 10;

  localparam int QPROD_W = 2 * POS_W;

  localparam logic [POS_W-1:0]   POS_ONE    = POS_W'(1) << POS_FRAC;
  localparam logic [QPROD_W-1:0] QPROD_HALF = QPROD_W'(1) << (POS_FRAC - 1);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [POS_W-1:0]         pos_t;

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  coef_index;
    coef_t             coef_value;
    logic              plane_sel;
    pos_t              pos_y;
    pos_t              pos_x;
  } in_t;

  typedef struct packed {
    coef_t shift_x;
    coef_t shift_y;
  } out_t;

  // Write request into the coefficient store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    coef_t            value;
  } wr_t;

  // Rounded product of two Q0.16 values that are both at most 1.0.
  function automatic pos_t qmul(input pos_t a, input pos_t b);
    logic [QPROD_W-1:0] p;
    p = {{POS_W{1'b0}}, a} * {{POS_W{1'b0}}, b} + QPROD_HALF;
    return p[POS_FRAC +: POS_W];
  endfunction

endpackage

// ===== design/bcse_coef_store.sv =====
// ----------------------------------------------------------------------------
// bcse_coef_store
// Coefficient store: one register row of eleven terms per color axis, written
// one slot at a time, read one full plane (x row and y row) at a time into
// registered outputs.
// ----------------------------------------------------------------------------
module bcse_coef_store #(
  parameter int COEF_ROWS = bcse_pkg::DEF_COEF_ROWS
) (
  input  logic                clk,
  input  bcse_pkg::wr_t       wr,
  input  logic                rd_en,
  input  logic                rd_plane,
  output bcse_pkg::coef_t     coef_r [bcse_pkg::AXES][bcse_pkg::TERMS]
);

  localparam int ROW_W      = bcse_pkg::ROW_W;
  localparam int IDX_W      = bcse_pkg::IDX_W;
  localparam int TERM_IDX_W = bcse_pkg::TERM_IDX_W;
  localparam int TERMS      = bcse_pkg::TERMS;
  // Rows past the fourth can never be selected, so they are not kept.
  localparam int STORE_ROWS = (COEF_ROWS < bcse_pkg::READ_ROWS) ?
                              COEF_ROWS : bcse_pkg::READ_ROWS;

  logic                  wr_hit;
  logic [ROW_W-1:0]      wr_row;
  logic [TERM_IDX_W-1:0] wr_term;

  bcse_pkg::coef_t row_val [bcse_pkg::READ_ROWS][TERMS];

  // Split the slot number into row and term with range compares.
  always_comb begin
    wr_hit  = 1'b0;
    wr_row  = '0;
    wr_term = '0;
    for (int r = 0; r < STORE_ROWS; r++) begin
      if (wr.index >= IDX_W'(r * TERMS) && wr.index < IDX_W'((r + 1) * TERMS)) begin
        wr_hit  = wr.en;
        wr_row  = ROW_W'(r);
        wr_term = TERM_IDX_W'(wr.index - IDX_W'(r * TERMS));
      end
    end
  end

  for (genvar r = 0; r < bcse_pkg::READ_ROWS; r++) begin : g_row
    if (r < STORE_ROWS) begin : g_store
      bcse_pkg::coef_t ent_r [TERMS];

      always_ff @(posedge clk) begin
        if (wr_hit && wr_row == ROW_W'(r)) begin
          ent_r[wr_term] <= wr.value;
        end
      end

      assign row_val[r] = ent_r;
    end else begin : g_zero
      // A row that does not exist reads as all-zero coefficients.
      assign row_val[r] = '{default: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int t = 0; t < TERMS; t++) begin
        coef_r[bcse_pkg::AXIS_X][t] <= rd_plane ? row_val[bcse_pkg::ROW_XB][t]
                                                : row_val[bcse_pkg::ROW_XR][t];
        coef_r[bcse_pkg::AXIS_Y][t] <= rd_plane ? row_val[bcse_pkg::ROW_YB][t]
                                                : row_val[bcse_pkg::ROW_YR][t];
      end
    end
  end

endmodule

// ===== design/bivariate_cubic_shift_eval_core.sv =====
// ----------------------------------------------------------------------------
// bivariate_cubic_shift_eval_core
// Evaluates the x and y shift polynomials of one color plane at a pixel
// position, and loads the coefficients that those polynomials use.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries two kinds of
//   items. A load item writes one coefficient slot and produces no result.
//   An evaluate item selects the red or blue rows and a position, and
//   produces one shift pair on the output channel (out_valid, out_stall,
//   out_data), in the order the items came in.
//   The block takes one item per clock while the pipeline is not held. An
//   evaluate result passes through nine register stages: clamp, squares,
//   cubes, coefficient read, coefficient products, rounding, two adder
//   levels and the saturating output register.
//   A load reaches the store in the third stage, the same stage where
//   evaluate items read it, so an evaluate sees every load sent before it.
//   Reset clears all valid bits; the coefficient store keeps no reset value
//   and must be loaded before the first evaluate item.
//   While the receiver stalls a held result, the whole pipeline holds and
//   in_stall is raised; items inside are neither lost nor repeated.
// ----------------------------------------------------------------------------
module bivariate_cubic_shift_eval_core #(
  parameter int COEF_ROWS = bcse_pkg::DEF_COEF_ROWS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bcse_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bcse_pkg::out_t out_data
);

  localparam int COEF_W   = bcse_pkg::COEF_W;
  localparam int POS_W    = bcse_pkg::POS_W;
  localparam int POS_FRAC = bcse_pkg::POS_FRAC;
  localparam int IDX_W    = bcse_pkg::IDX_W;
  localparam int TERMS    = bcse_pkg::TERMS;
  localparam int AXES     = bcse_pkg::AXES;
  localparam int PROD_W   = COEF_W + POS_W + 1;
  localparam int TERM_W   = COEF_W + 1;
  localparam int SUM_W    = COEF_W + $clog2(TERMS) + 1;
  localparam int GRP_SIZE = 3;
  localparam int GROUPS   = (TERMS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int HALVES   = 2;
  localparam int GRP_PER_HALF = (GROUPS + HALVES - 1) / HALVES;

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (POS_FRAC - 1);

  logic adv;
  logic accept;

  // Stage 1: clamped position.
  logic                  s1_vld_r, s1_vld_nxt;
  bcse_pkg::mode_t       s1_mode_r;
  logic [IDX_W-1:0]      s1_idx_r;
  bcse_pkg::coef_t       s1_val_r;
  logic                  s1_plane_r;
  bcse_pkg::pos_t        s1_x_r, s1_y_r;

  // Stage 2: squares and xy.
  logic                  s2_vld_r;
  bcse_pkg::mode_t       s2_mode_r;
  logic [IDX_W-1:0]      s2_idx_r;
  bcse_pkg::coef_t       s2_val_r;
  logic                  s2_plane_r;
  bcse_pkg::pos_t        s2_x_r, s2_y_r, s2_x2_r, s2_y2_r, s2_xy_r;

  // Stage 3: all eleven monomials; loads are written from here.
  logic                  s3_vld_r;
  bcse_pkg::mode_t       s3_mode_r;
  logic [IDX_W-1:0]      s3_idx_r;
  bcse_pkg::coef_t       s3_val_r;
  logic                  s3_plane_r;
  bcse_pkg::pos_t        s3_mono_r [TERMS];

  // Stage 4: coefficients of the selected plane.
  logic                  s4_vld_r, s4_vld_nxt;
  bcse_pkg::pos_t        s4_mono_r [TERMS];
  bcse_pkg::coef_t       coef_r [AXES][TERMS];
  bcse_pkg::wr_t         st_wr;

  // Stage 5 to 8: products, rounded terms, adder levels.
  logic                  s5_vld_r;
  logic signed [PROD_W-1:0] s5_prod_r [AXES][TERMS];
  logic                  s6_vld_r;
  logic signed [TERM_W-1:0] s6_term_r [AXES][TERMS];
  logic signed [TERM_W-1:0] s6_term_nxt [AXES][TERMS];
  logic                  s7_vld_r;
  logic signed [SUM_W-1:0]  s7_grp_r [AXES][GROUPS];
  logic signed [SUM_W-1:0]  s7_grp_nxt [AXES][GROUPS];
  logic                  s8_vld_r;
  logic signed [SUM_W-1:0]  s8_half_r [AXES][HALVES];
  logic signed [SUM_W-1:0]  s8_half_nxt [AXES][HALVES];

  // Output register.
  logic                  out_vld_r;
  bcse_pkg::out_t        out_data_r, out_data_nxt;
  bcse_pkg::coef_t       shift_nxt [AXES];

  // The pipeline moves as a whole unless a result waits in the output
  // register and the receiver stalls.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  assign s1_vld_nxt = accept;
  assign s4_vld_nxt = s3_vld_r && (s3_mode_r == bcse_pkg::MODE_EVAL);

  assign st_wr.en    = adv && s3_vld_r && (s3_mode_r == bcse_pkg::MODE_LOAD);
  assign st_wr.index = s3_idx_r;
  assign st_wr.value = s3_val_r;

  bcse_coef_store #(
    .COEF_ROWS(COEF_ROWS)
  ) u_store (
    .clk      (clk),
    .wr       (st_wr),
    .rd_en    (adv),
    .rd_plane (s3_plane_r),
    .coef_r   (coef_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s4_vld_nxt;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      out_vld_r <= s8_vld_r;
    end
  end

  // Rounding: half away from zero, so negative products round with one less.
  always_comb begin
    logic signed [PROD_W-1:0] rnd;
    rnd = '0;
    for (int a = 0; a < AXES; a++) begin
      for (int t = 0; t < TERMS; t++) begin
        rnd = s5_prod_r[a][t] + $signed(RND_HALF)
              - $signed(PROD_W'(s5_prod_r[a][t][PROD_W-1]));
        s6_term_nxt[a][t] = rnd[POS_FRAC +: TERM_W];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int g = 0; g < GROUPS; g++) begin
        s7_grp_nxt[a][g] = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
          if (g * GRP_SIZE + k < TERMS) begin
            s7_grp_nxt[a][g] = s7_grp_nxt[a][g]
                               + SUM_W'(s6_term_r[a][g * GRP_SIZE + k]);
          end
        end
      end
      for (int h = 0; h < HALVES; h++) begin
        s8_half_nxt[a][h] = '0;
        for (int k = 0; k < GRP_PER_HALF; k++) begin
          if (h * GRP_PER_HALF + k < GROUPS) begin
            s8_half_nxt[a][h] = s8_half_nxt[a][h] + s7_grp_r[a][h * GRP_PER_HALF + k];
          end
        end
      end
    end
  end

  // Final add, then saturation to the signed coefficient range.
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    sum = '0;
    for (int a = 0; a < AXES; a++) begin
      sum = s8_half_r[a][0] + s8_half_r[a][1];
      if (sum[SUM_W-1:COEF_W-1] == '0 || sum[SUM_W-1:COEF_W-1] == '1) begin
        shift_nxt[a] = sum[COEF_W-1:0];
      end else if (sum[SUM_W-1]) begin
        shift_nxt[a] = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        shift_nxt[a] = {1'b0, {(COEF_W-1){1'b1}}};
      end
    end
    out_data_nxt.shift_x = shift_nxt[bcse_pkg::AXIS_X];
    out_data_nxt.shift_y = shift_nxt[bcse_pkg::AXIS_Y];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r  <= in_data.mode;
      s1_idx_r   <= in_data.coef_index;
      s1_val_r   <= in_data.coef_value;
      s1_plane_r <= in_data.plane_sel;
      s1_x_r     <= (in_data.pos_x > bcse_pkg::POS_ONE) ? bcse_pkg::POS_ONE : in_data.pos_x;
      s1_y_r     <= (in_data.pos_y > bcse_pkg::POS_ONE) ? bcse_pkg::POS_ONE : in_data.pos_y;

      s2_mode_r  <= s1_mode_r;
      s2_idx_r   <= s1_idx_r;
      s2_val_r   <= s1_val_r;
      s2_plane_r <= s1_plane_r;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_x2_r    <= bcse_pkg::qmul(s1_x_r, s1_x_r);
      s2_y2_r    <= bcse_pkg::qmul(s1_y_r, s1_y_r);
      s2_xy_r    <= bcse_pkg::qmul(s1_x_r, s1_y_r);

      s3_mode_r  <= s2_mode_r;
      s3_idx_r   <= s2_idx_r;
      s3_val_r   <= s2_val_r;
      s3_plane_r <= s2_plane_r;
      s3_mono_r[bcse_pkg::T_ONE]  <= bcse_pkg::POS_ONE;
      s3_mono_r[bcse_pkg::T_X]    <= s2_x_r;
      s3_mono_r[bcse_pkg::T_Y]    <= s2_y_r;
      s3_mono_r[bcse_pkg::T_X2]   <= s2_x2_r;
      s3_mono_r[bcse_pkg::T_Y2]   <= s2_y2_r;
      s3_mono_r[bcse_pkg::T_X3]   <= bcse_pkg::qmul(s2_x2_r, s2_x_r);
      s3_mono_r[bcse_pkg::T_Y3]   <= bcse_pkg::qmul(s2_y2_r, s2_y_r);
      s3_mono_r[bcse_pkg::T_XY]   <= s2_xy_r;
      s3_mono_r[bcse_pkg::T_X2Y]  <= bcse_pkg::qmul(s2_x2_r, s2_y_r);
      s3_mono_r[bcse_pkg::T_XY2]  <= bcse_pkg::qmul(s2_x_r, s2_y2_r);
      s3_mono_r[bcse_pkg::T_X2Y2] <= bcse_pkg::qmul(s2_x2_r, s2_y2_r);

      s4_mono_r <= s3_mono_r;

      for (int a = 0; a < AXES; a++) begin
        for (int t = 0; t < TERMS; t++) begin
          s5_prod_r[a][t] <= PROD_W'($signed(coef_r[a][t]))
                             * PROD_W'($signed({1'b0, s4_mono_r[t]}));
        end
      end

      s6_term_r  <= s6_term_nxt;
      s7_grp_r   <= s7_grp_nxt;
      s8_half_r  <= s8_half_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/bcse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcse_checker
// Watches both channels of the shift evaluator, keeps a shadow of the
// coefficient store, predicts every shift pair and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bcse_checker #(
  parameter int COEF_ROWS = bcse_pkg::DEF_COEF_ROWS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  bcse_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  bcse_pkg::out_t out_data,
  output int             fail_count,
  output int             pending
);

  localparam int TERMS    = bcse_pkg::TERMS;
  localparam int POS_FRAC = bcse_pkg::POS_FRAC;
  localparam int COEF_W   = bcse_pkg::COEF_W;
  localparam int SLOTS    = COEF_ROWS * TERMS;
  localparam longint SHIFT_MAX = (longint'(1) << (COEF_W - 1)) - 1;
  localparam longint SHIFT_MIN = -SHIFT_MAX - 1;

  bcse_pkg::coef_t  coef_shadow [SLOTS];
  bcse_pkg::out_t   shift_q [$];
  bcse_pkg::out_t   want;
  int               err_total = 0;

  function automatic longint round_prod(input longint a, input longint b);
    return (a * b + (longint'(1) << (POS_FRAC - 1))) >>> POS_FRAC;
  endfunction

  // Coefficient times monomial, back on the coefficient scale, rounded half
  // away from zero.
  function automatic longint scaled_term(input bcse_pkg::coef_t c, input longint m);
    longint mag;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    mag = (mag * m + (longint'(1) << (POS_FRAC - 1))) >>> POS_FRAC;
    return (c < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_pos(input bcse_pkg::pos_t p);
    return (p > bcse_pkg::POS_ONE) ? longint'(bcse_pkg::POS_ONE) : longint'(p);
  endfunction

  function automatic bcse_pkg::out_t predict_shifts(input bcse_pkg::in_t item);
    longint px;
    longint py;
    longint x2;
    longint y2;
    longint mono [TERMS];
    longint acc;
    int     row;
    bcse_pkg::out_t res;
    px = clamp_pos(item.pos_x);
    py = clamp_pos(item.pos_y);
    x2 = round_prod(px, px);
    y2 = round_prod(py, py);
    mono[bcse_pkg::T_ONE]  = longint'(bcse_pkg::POS_ONE);
    mono[bcse_pkg::T_X]    = px;
    mono[bcse_pkg::T_Y]    = py;
    mono[bcse_pkg::T_X2]   = x2;
    mono[bcse_pkg::T_Y2]   = y2;
    mono[bcse_pkg::T_X3]   = round_prod(x2, px);
    mono[bcse_pkg::T_Y3]   = round_prod(y2, py);
    mono[bcse_pkg::T_XY]   = round_prod(px, py);
    mono[bcse_pkg::T_X2Y]  = round_prod(x2, py);
    mono[bcse_pkg::T_XY2]  = round_prod(px, y2);
    mono[bcse_pkg::T_X2Y2] = round_prod(x2, y2);
    res = '0;
    for (int axis = 0; axis < bcse_pkg::AXES; axis++) begin
      row = 2 * int'(item.plane_sel) + axis;
      acc = 0;
      // Rows past the end of the store read as zero coefficients.
      if (row < COEF_ROWS) begin
        for (int t = 0; t < TERMS; t++) begin
          acc += scaled_term(coef_shadow[row * TERMS + t], mono[t]);
        end
      end
      if (acc > SHIFT_MAX) acc = SHIFT_MAX;
      if (acc < SHIFT_MIN) acc = SHIFT_MIN;
      if (axis == bcse_pkg::AXIS_X) res.shift_x = bcse_pkg::coef_t'(acc);
      else res.shift_y = bcse_pkg::coef_t'(acc);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (shift_q.size() == 0) begin
          $error("result transfer with nothing expected: shift_x %0d, shift_y %0d",
                 out_data.shift_x, out_data.shift_y);
          err_total++;
        end else begin
          want = shift_q.pop_front();
          if (out_data.shift_x !== want.shift_x) begin
            $error("shift_x: expected %0d, actual %0d", want.shift_x, out_data.shift_x);
            err_total++;
          end
          if (out_data.shift_y !== want.shift_y) begin
            $error("shift_y: expected %0d, actual %0d", want.shift_y, out_data.shift_y);
            err_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == bcse_pkg::MODE_LOAD) begin
          // Loads to slots past the store are dropped.
          if (int'(in_data.coef_index) < SLOTS) begin
            coef_shadow[in_data.coef_index] = in_data.coef_value;
          end
        end else begin
          shift_q.push_back(predict_shifts(in_data));
        end
      end
    end
    fail_count <= err_total;
    pending    <= shift_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the bivariate cubic shift evaluator: fills the coefficient
// store, runs directed corner positions and coefficients, then random load
// and evaluate streams under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int    COEF_W   = bcse_pkg::COEF_W;
  localparam int    IDX_W    = bcse_pkg::IDX_W;
  localparam int    TERMS    = bcse_pkg::TERMS;
  localparam bcse_pkg::coef_t COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam bcse_pkg::coef_t COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam int    SLOTS    = bcse_pkg::DEF_COEF_ROWS * TERMS;
  localparam int    PHASES   = 4;
  localparam int    PHASE_ITEMS = 246;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  bcse_pkg::in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bcse_pkg::out_t out_data;

  int fail_count;
  int pending;
  int src_gap_pct   = 0;
  int sink_hold_pct = 0;

  int gap_tab  [PHASES] = '{0, 58, 0, 14};
  int hold_tab [PHASES] = '{0, 0, 58, 14};

  always #2 clk = ~clk;

  bivariate_cubic_shift_eval_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bcse_checker shift_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_hold_pct);
  end

  function automatic bcse_pkg::coef_t rand_coef();
    bcse_pkg::coef_t v;
    case ($urandom_range(7))
      0: v = COEF_MAX;
      1: v = COEF_MIN;
      default: begin
        v = $urandom;
        v = v >>> $urandom_range(0, 7);
      end
    endcase
    return v;
  endfunction

  // Mostly in-range positions, with the ends and some values above one.
  function automatic bcse_pkg::pos_t rand_pos();
    case ($urandom_range(9))
      0: return '0;
      1: return bcse_pkg::POS_ONE;
      2: return bcse_pkg::pos_t'($urandom_range(65537, 131071));
      default: return bcse_pkg::pos_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic bcse_pkg::in_t mk_load(input int slot, input bcse_pkg::coef_t value);
    bcse_pkg::in_t item;
    item.mode       = bcse_pkg::MODE_LOAD;
    item.coef_index = slot[IDX_W-1:0];
    item.coef_value = value;
    item.plane_sel  = 1'($urandom_range(1));
    item.pos_y      = bcse_pkg::pos_t'($urandom);
    item.pos_x      = bcse_pkg::pos_t'($urandom);
    return item;
  endfunction

  function automatic bcse_pkg::in_t mk_eval(input logic plane, input bcse_pkg::pos_t x,
                                            input bcse_pkg::pos_t y);
    bcse_pkg::in_t item;
    item.mode       = bcse_pkg::MODE_EVAL;
    item.coef_index = IDX_W'($urandom);
    item.coef_value = $urandom;
    item.plane_sel  = plane;
    item.pos_y      = y;
    item.pos_x      = x;
    return item;
  endfunction

  function automatic bcse_pkg::in_t rand_item();
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(4) == 0) return mk_load($urandom_range(SLOTS, 63), rand_coef());
      return mk_load($urandom_range(0, SLOTS - 1), rand_coef());
    end
    return mk_eval(1'($urandom_range(1)), rand_pos(), rand_pos());
  endfunction

  // Holds valid until the transfer happens; valid is only lowered for gaps.
  task automatic send(input bcse_pkg::in_t item);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every slot is written before the first evaluate. The red rows hold the
    // extremes so that both saturation directions show up.
    for (int s = 0; s < SLOTS; s++) begin
      if (s / TERMS == bcse_pkg::ROW_XR) send(mk_load(s, COEF_MAX));
      else if (s / TERMS == bcse_pkg::ROW_YR) send(mk_load(s, COEF_MIN));
      else send(mk_load(s, rand_coef()));
    end

    send(mk_eval(1'b0, bcse_pkg::POS_ONE, bcse_pkg::POS_ONE));
    send(mk_eval(1'b0, '0, '0));
    send(mk_eval(1'b0, 17'h1FFFF, 17'h1FFFF));
    send(mk_eval(1'b0, 17'h10001, '0));
    send(mk_eval(1'b0, '0, 17'h0FFFF));
    send(mk_eval(1'b1, '0, '0));
    send(mk_eval(1'b1, bcse_pkg::POS_ONE, bcse_pkg::POS_ONE));
    send(mk_eval(1'b1, 17'h08000, 17'h08000));
    send(mk_eval(1'b1, 17'h0FFFF, 17'h00001));
    // Half-way products of unit coefficients round away from zero.
    send(mk_load(bcse_pkg::ROW_XB * TERMS + bcse_pkg::T_X, -1));
    send(mk_load(bcse_pkg::ROW_YB * TERMS + bcse_pkg::T_X, 1));
    send(mk_eval(1'b1, 17'h08000, '0));
    send(mk_eval(1'b1, 17'h18000, '0));
    // Slots past the store must leave it untouched.
    send(mk_load(SLOTS, COEF_MAX));
    send(mk_load(63, COEF_MIN));
    send(mk_eval(1'b1, '0, bcse_pkg::POS_ONE));
    send(mk_load(bcse_pkg::ROW_YB * TERMS + bcse_pkg::T_X2Y2, COEF_MIN));
    send(mk_eval(1'b1, bcse_pkg::POS_ONE, bcse_pkg::POS_ONE));
    send(mk_load(bcse_pkg::ROW_XR * TERMS + bcse_pkg::T_ONE, '0));
    send(mk_eval(1'b0, '0, '0));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      src_gap_pct   = gap_tab[ph];
      sink_hold_pct = hold_tab[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send(rand_item());
      end
      drain();
    end

    sink_hold_pct = 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bivariate_cubic_shift_eval_core regression: pass");
    end else begin
      $display("bivariate_cubic_shift_eval_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bivariate_cubic_shift_eval_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/bcse_pkg.sv
design/bcse_coef_store.sv
design/bivariate_cubic_shift_eval_core.sv
tb/bcse_checker.sv
tb/testbench.sv
